// ===== rtl/capdu_pkg.sv =====
// ----------------------------------------------------------------------------
// capdu_pkg: shared types and helpers for the command APDU framer
// Job record passed from the front end to the byte emitter, and Le encoding.
// ----------------------------------------------------------------------------
package capdu_pkg;

   localparam logic OP_HEADER = 1'b0;
   localparam logic OP_DATA   = 1'b1;

   localparam int JOB_BYTES           = 7;
   localparam int JOB_COUNT_W         = 3;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [15:0] LEN_SHORT_LIMIT = 16'd256;
   localparam logic [7:0]  BYTE_ZERO       = 8'h00;

   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] bytes;
      logic [JOB_COUNT_W-1:0]    count;
      logic                      last_frame;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } queue_slot_type;

   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;
   } le_field_type;

   function automatic le_field_type encode_le(input logic [15:0] ne, input logic extended_lc);
      le_field_type f;
      f.bytes = '0;
      f.count = 2'd0;
      if (ne == 16'd0) begin
         f.count = 2'd0;
      end else if (ne < LEN_SHORT_LIMIT) begin
         f.bytes[0] = ne[7:0];
         f.count    = 2'd1;
      end else if (ne == LEN_SHORT_LIMIT) begin
         f.bytes[0] = BYTE_ZERO;
         f.count    = 2'd1;
      end else if (!extended_lc) begin
         f.bytes[0] = BYTE_ZERO;
         f.bytes[1] = ne[15:8];
         f.bytes[2] = ne[7:0];
         f.count    = 2'd3;
      end else begin
         f.bytes[0] = ne[15:8];
         f.bytes[1] = ne[7:0];
         f.count    = 2'd2;
      end
      return f;
   endfunction

endpackage

// ===== rtl/capdu_if.sv =====
// ----------------------------------------------------------------------------
// capdu_if: request and response channels of the command APDU framer
// Valid/ready channels carrying the input item and the output byte.
// ----------------------------------------------------------------------------
interface capdu_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [7:0]  class_byte;
   logic [7:0]  instruction_byte;
   logic [7:0]  param_one;
   logic [7:0]  param_two;
   logic [15:0] body_length;
   logic [15:0] expected_length;
   logic [7:0]  data_byte;

   modport source (
      output valid, operation, class_byte, instruction_byte, param_one, param_two,
             body_length, expected_length, data_byte,
      input  ready
   );
   modport sink (
      input  valid, operation, class_byte, instruction_byte, param_one, param_two,
             body_length, expected_length, data_byte,
      output ready
   );
endinterface

interface capdu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       frame_end;

   modport source (output valid, out_byte, frame_end, input ready);
   modport sink   (input valid, out_byte, frame_end, output ready);
endinterface

// ===== rtl/capdu_front.sv =====
// ----------------------------------------------------------------------------
// capdu_front: item classifier
// Accepts words, tracks the open command and turns each word, but a stray data byte, into a job.
// ----------------------------------------------------------------------------
module capdu_front
   import capdu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   capdu_req_if.sink      req_chan,
   output queue_slot_type push,
   input  logic           push_ready
);

   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [15:0] saved_expected_ff, saved_expected_in;
   logic        long_used_ff, long_used_in;
   logic        open_ff, open_in;

   logic         accept;
   le_field_type le_hdr;
   le_field_type le_body;

   assign req_chan.ready = push_ready;
   assign accept         = req_chan.valid && push_ready;

   assign le_hdr  = encode_le(req_chan.expected_length, 1'b0);
   assign le_body = encode_le(saved_expected_ff, long_used_ff);

   always_comb begin
      push.valid           = 1'b0;
      push.job.bytes       = '0;
      push.job.count       = '0;
      push.job.last_frame  = 1'b0;
      bytes_left_in        = bytes_left_ff;
      saved_expected_in    = saved_expected_ff;
      long_used_in         = long_used_ff;
      open_in              = open_ff;
      unique case (req_chan.operation)
         OP_HEADER: begin
            push.valid         = accept;
            push.job.bytes[0]  = req_chan.class_byte;
            push.job.bytes[1]  = req_chan.instruction_byte;
            push.job.bytes[2]  = req_chan.param_one;
            push.job.bytes[3]  = req_chan.param_two;
            if (req_chan.body_length == 16'd0) begin
               push.job.bytes[4]   = le_hdr.bytes[0];
               push.job.bytes[5]   = le_hdr.bytes[1];
               push.job.bytes[6]   = le_hdr.bytes[2];
               push.job.count      = 3'd4 + {1'b0, le_hdr.count};
               push.job.last_frame = 1'b1;
               bytes_left_in       = 16'd0;
               saved_expected_in   = 16'd0;
               long_used_in        = 1'b0;
               open_in             = 1'b0;
            end else begin
               if (req_chan.body_length < LEN_SHORT_LIMIT) begin
                  push.job.bytes[4] = req_chan.body_length[7:0];
                  push.job.count    = 3'd5;
                  long_used_in      = 1'b0;
               end else begin
                  push.job.bytes[4] = BYTE_ZERO;
                  push.job.bytes[5] = req_chan.body_length[15:8];
                  push.job.bytes[6] = req_chan.body_length[7:0];
                  push.job.count    = 3'd7;
                  long_used_in      = 1'b1;
               end
               bytes_left_in     = req_chan.body_length;
               saved_expected_in = req_chan.expected_length;
               open_in           = 1'b1;
            end
         end
         OP_DATA: begin
            // drop stray data bytes
            if (open_ff && bytes_left_ff != 16'd0) begin
               push.valid        = accept;
               push.job.bytes[0] = req_chan.data_byte;
               push.job.count    = 3'd1;
               bytes_left_in     = bytes_left_ff - 16'd1;
               if (bytes_left_ff == 16'd1) begin
                  push.job.bytes[1]   = le_body.bytes[0];
                  push.job.bytes[2]   = le_body.bytes[1];
                  push.job.bytes[3]   = le_body.bytes[2];
                  push.job.count      = 3'd1 + {1'b0, le_body.count};
                  push.job.last_frame = 1'b1;
                  saved_expected_in   = 16'd0;
                  long_used_in        = 1'b0;
                  open_in             = 1'b0;
               end
            end
         end
         default: begin
            push.valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff     <= 16'd0;
         saved_expected_ff <= 16'd0;
         long_used_ff      <= 1'b0;
         open_ff           <= 1'b0;
      end else if (accept) begin
         bytes_left_ff     <= bytes_left_in;
         saved_expected_ff <= saved_expected_in;
         long_used_ff      <= long_used_in;
         open_ff           <= open_in;
      end
   end

endmodule

// ===== rtl/capdu_queue.sv =====
// ----------------------------------------------------------------------------
// capdu_queue: job queue
// Short first-in first-out store of jobs between the front end and emitter.
// ----------------------------------------------------------------------------
module capdu_queue
   import capdu_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  queue_slot_type push,
   output logic           push_ready,
   output queue_slot_type head,
   input  logic           pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.job   = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push.job;
      end
   end

endmodule

// ===== rtl/capdu_back.sv =====
// ----------------------------------------------------------------------------
// capdu_back: byte emitter
// Walks the head job one byte per cycle, while the output is not stalled, into the registered output byte.
// ----------------------------------------------------------------------------
module capdu_back
   import capdu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_slot_type head,
   output logic           pop,
   capdu_rsp_if.source    rsp_chan
);

   logic [JOB_COUNT_W-1:0] idx_ff, idx_in;
   logic                   valid_ff, valid_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   end_ff, end_in;
   logic                   can_load;
   logic                   last_of_job;

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.out_byte  = byte_ff;
   assign rsp_chan.frame_end = end_ff;

   assign can_load    = !valid_ff || rsp_chan.ready;
   assign last_of_job = (idx_ff == head.job.count - 1'b1);
   assign pop         = can_load && head.valid && last_of_job;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      if (can_load) begin
         valid_in = head.valid;
         byte_in  = head.job.bytes[idx_ff];
         end_in   = head.job.last_frame && last_of_job;
         if (head.valid) begin
            idx_in = last_of_job ? '0 : idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= end_in;
   end

endmodule

// ===== rtl/command_apdu_framer.sv =====
// ----------------------------------------------------------------------------
// command_apdu_framer: ISO 7816-4 command APDU byte framer
// Header words produce CLA, INS, P1, P2 and Lc, or, for an empty body, Le in
// place of Lc; body words pass through one byte each, the last followed by Le.
// Output is one byte per cycle, while not stalled, from a registered stage: a
// header gives four to seven output bytes, a body byte one, or up to four when
// Le follows it. The single output byte port sets the rate. Input words are
// taken every cycle while the job queue of QUEUE_DEPTH entries has room, so
// a stalled output does not stop intake until the queue fills; an item passes
// the queue, then the output register. Stray body bytes are taken and dropped.
// ----------------------------------------------------------------------------
module command_apdu_framer
   import capdu_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   capdu_req_if.sink    req_chan,
   capdu_rsp_if.source  rsp_chan
);

   queue_slot_type push;
   queue_slot_type head;
   logic           push_ready;
   logic           pop;

   capdu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push       (push),
      .push_ready (push_ready)
   );

   capdu_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .head       (head),
      .pop        (pop)
   );

   capdu_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
